### sv/job_timing_statistics_monitor_macros.svh
// ----------------------------------------------------------------------------
// Job timing statistics monitor assertion macros
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef JOB_TIMING_STATISTICS_MONITOR_MACROS_SVH
`define JOB_TIMING_STATISTICS_MONITOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define JTSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jtsm assertion failed");

// Consequent checked in the cycle after the antecedent.
`define JTSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jtsm assertion failed");

`endif

### sv/jtsm_pkg.sv
// ----------------------------------------------------------------------------
// Job timing statistics monitor package
// Shared constants, types and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jtsm_pkg;

  localparam int HIST_BINS_DEF = 10;
  localparam int EDGE_CNT      = HIST_BINS_DEF - 1;
  localparam int BIN_W         = $clog2(HIST_BINS_DEF);

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [31:0] BIN_EDGES [EDGE_CNT] = '{
    32'd5000, 32'd10000, 32'd15000, 32'd20000, 32'd25000,
    32'd30000, 32'd32000, 32'd34000, 32'd36000
  };

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef struct packed {
    logic [31:0] job_count;
    logic [47:0] exec_total;
    logic [31:0] exec_min;
    logic [31:0] exec_max;
    logic [47:0] response_total;
    logic [31:0] response_min;
    logic [31:0] response_max;
    logic [31:0] miss_count;
    logic [31:0] worst_lateness;
    logic        missed_now;
  } stats_t;

  typedef struct packed {
    logic wr_go;
    op_t  op;
  } hist_ctl_t;

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 32'd1;
  endfunction

  function automatic logic [BIN_W-1:0] pick_bin(input logic [31:0] t);
    logic [BIN_W-1:0] b;
    b = BIN_W'(EDGE_CNT);
    for (int i = EDGE_CNT - 1; i >= 0; i--) begin
      if (t < BIN_EDGES[i]) begin
        b = BIN_W'(i);
      end
    end
    return b;
  endfunction

endpackage

### sv/jtsm_if.sv
// ----------------------------------------------------------------------------
// Job timing statistics monitor channels
// Valid/ready interfaces for job records and statistics results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jtsm_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] exec_time;
  logic [31:0] response_time;
  logic [3:0]  bin_select;

  modport source (output valid, output opcode, output exec_time,
                  output response_time, output bin_select, input ready);
  modport sink (input valid, input opcode, input exec_time,
                input response_time, input bin_select, output ready);
endinterface

interface jtsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] job_count;
  logic [47:0] exec_total;
  logic [31:0] exec_min;
  logic [31:0] exec_max;
  logic [47:0] response_total;
  logic [31:0] response_min;
  logic [31:0] response_max;
  logic [31:0] miss_count;
  logic [31:0] worst_lateness;
  logic        missed_now;
  logic [31:0] bin_count;

  modport source (output valid, output job_count, output exec_total,
                  output exec_min, output exec_max, output response_total,
                  output response_min, output response_max, output miss_count,
                  output worst_lateness, output missed_now, output bin_count,
                  input ready);
  modport sink (input valid, input job_count, input exec_total,
                input exec_min, input exec_max, input response_total,
                input response_min, input response_max, input miss_count,
                input worst_lateness, input missed_now, input bin_count,
                output ready);
endinterface

### sv/jtsm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/jtsm_hist.sv
// ----------------------------------------------------------------------------
// Job timing statistics monitor histogram
// Read-modify-write of the execution time bins with forwarding and valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtsm_hist #(
  parameter int HIST_BINS = jtsm_pkg::HIST_BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [$clog2(HIST_BINS)-1:0] ebin,
  input  logic [$clog2(HIST_BINS)-1:0] sel_addr,
  input  logic                         sel_ok,
  input  jtsm_pkg::hist_ctl_t          ctl,
  output logic [31:0]                  bin_count
);
  import jtsm_pkg::*;

  localparam int AW = $clog2(HIST_BINS);

  logic [HIST_BINS-1:0] vld;
  logic [AW-1:0]        ebin_q;
  logic [AW-1:0]        sel_q;
  logic                 sel_ok_q;
  logic                 hit_e;
  logic                 hit_s;
  logic [31:0]          fwd;
  logic [31:0]          rd_e;
  logic [31:0]          rd_s;
  logic [31:0]          cnt_e;
  logic [31:0]          cnt_s;
  logic [31:0]          wdata;
  logic                 wr;
  logic                 clr;

  assign wr  = ctl.wr_go && (ctl.op == OP_RECORD);
  assign clr = ctl.wr_go && (ctl.op == OP_CLEAR);

  jtsm_ram #(.WIDTH(32), .DEPTH(HIST_BINS)) u_ram_e (
    .clk(clk), .we(wr), .waddr(ebin_q), .wdata(wdata),
    .re(accept), .raddr(ebin), .rdata(rd_e)
  );

  jtsm_ram #(.WIDTH(32), .DEPTH(HIST_BINS)) u_ram_s (
    .clk(clk), .we(wr), .waddr(ebin_q), .wdata(wdata),
    .re(accept), .raddr(sel_addr), .rdata(rd_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (clr) begin
      vld <= '0;
    end else if (wr) begin
      vld[ebin_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ebin_q   <= ebin;
      sel_q    <= sel_addr;
      sel_ok_q <= sel_ok;
      hit_e    <= wr && (ebin_q == ebin);
      hit_s    <= wr && (ebin_q == sel_addr);
      fwd      <= wdata;
    end
  end

  always_comb begin
    cnt_e = hit_e ? fwd : (vld[ebin_q] ? rd_e : 32'd0);
    cnt_s = hit_s ? fwd : (vld[sel_q] ? rd_s : 32'd0);
    wdata = inc_sat32(cnt_e);
    if (ctl.op == OP_CLEAR || !sel_ok_q) begin
      bin_count = 32'd0;
    end else if (sel_q == ebin_q) begin
      bin_count = wdata;
    end else begin
      bin_count = cnt_s;
    end
  end

endmodule

### sv/jtsm_stats.sv
// ----------------------------------------------------------------------------
// Job timing statistics monitor scalar statistics
// Counts, saturating totals, extremes, deadline misses and lateness.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtsm_stats (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  jtsm_pkg::op_t    op,
  input  logic [31:0]      et,
  input  logic [31:0]      rt,
  input  logic [31:0]      dl,
  output jtsm_pkg::stats_t view
);
  import jtsm_pkg::*;

  logic [31:0] jobs;
  logic [47:0] esum;
  logic [31:0] elo;
  logic [31:0] ehi;
  logic [47:0] rsum;
  logic [31:0] rlo;
  logic [31:0] rhi;
  logic [31:0] misses;
  logic [31:0] peak;

  logic        first;
  logic [48:0] esum_w;
  logic [48:0] rsum_w;
  logic        late_hit;
  logic [31:0] late;

  always_comb begin
    first    = (jobs == 32'd0);
    esum_w   = {1'b0, esum} + {17'd0, et};
    rsum_w   = {1'b0, rsum} + {17'd0, rt};
    late_hit = (rt > dl);
    late     = rt - dl;
    view     = '0;
    if (op == OP_RECORD) begin
      view.job_count      = inc_sat32(jobs);
      view.exec_total     = esum_w[48] ? SUM_MAX : esum_w[47:0];
      view.exec_min       = (first || et < elo) ? et : elo;
      view.exec_max       = (first || et > ehi) ? et : ehi;
      view.response_total = rsum_w[48] ? SUM_MAX : rsum_w[47:0];
      view.response_min   = (first || rt < rlo) ? rt : rlo;
      view.response_max   = (first || rt > rhi) ? rt : rhi;
      view.miss_count     = late_hit ? inc_sat32(misses) : misses;
      view.worst_lateness = (late_hit && late > peak) ? late : peak;
      view.missed_now     = late_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jobs   <= '0;
      esum   <= '0;
      elo    <= '0;
      ehi    <= '0;
      rsum   <= '0;
      rlo    <= '0;
      rhi    <= '0;
      misses <= '0;
      peak   <= '0;
    end else if (adv) begin
      jobs   <= view.job_count;
      esum   <= view.exec_total;
      elo    <= view.exec_min;
      ehi    <= view.exec_max;
      rsum   <= view.response_total;
      rlo    <= view.response_min;
      rhi    <= view.response_max;
      misses <= view.miss_count;
      peak   <= view.worst_lateness;
    end
  end

endmodule

### sv/job_timing_statistics_monitor.sv
// ----------------------------------------------------------------------------
// Job timing statistics monitor
// Per-task job timing statistics with an execution time histogram.
// ----------------------------------------------------------------------------
// The block accepts one job record or clear transaction per clock unless the
// result side stalls it, and returns one result per transaction, passing
// through the stage-1 registers and histogram RAM read, then the output
// register. Back-to-back jobs that hit the same bin are forwarded, and clears
// act at once through per-bin valid bits, so there is no clearing pass after
// reset. The user must write the deadline through cfg_we and cfg_data only
// while no transaction is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module job_timing_statistics_monitor #(
  parameter int HIST_BINS = jtsm_pkg::HIST_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  jtsm_in_if.sink     in_ch,
  jtsm_out_if.source  res
);
  import jtsm_pkg::*;

  localparam int AW = $clog2(HIST_BINS);

  logic        deadline;
  logic [31:0] deadline_time;
  logic        s1_valid;
  op_t         s1_op;
  logic [31:0] s1_et;
  logic [31:0] s1_rt;
  logic        s1_adv;
  logic        accept;
  logic        out_valid;
  stats_t      out_stat;
  logic [31:0] out_bin;
  stats_t      view;
  logic [31:0] bin_count;
  logic        sel_ok;
  logic [AW-1:0] sel_addr;
  logic [AW-1:0] ebin;
  hist_ctl_t   ctl;

  assign deadline    = cfg_we;
  assign s1_adv      = s1_valid && (!out_valid || res.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sel_ok      = ({28'd0, in_ch.bin_select} < 32'(HIST_BINS));
  assign sel_addr    = sel_ok ? AW'(in_ch.bin_select) : '0;
  assign ebin        = AW'(pick_bin(in_ch.exec_time));
  assign ctl         = '{wr_go: s1_adv, op: s1_op};

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_time <= '0;
    end else if (deadline) begin
      deadline_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= op_t'(in_ch.opcode);
      s1_et <= in_ch.exec_time;
      s1_rt <= in_ch.response_time;
    end
  end

  jtsm_stats u_stats (
    .clk(clk), .rst(rst), .adv(s1_adv), .op(s1_op),
    .et(s1_et), .rt(s1_rt), .dl(deadline_time), .view(view)
  );

  jtsm_hist #(.HIST_BINS(HIST_BINS)) u_hist (
    .clk(clk), .rst(rst), .accept(accept), .ebin(ebin),
    .sel_addr(sel_addr), .sel_ok(sel_ok), .ctl(ctl), .bin_count(bin_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_stat <= view;
      out_bin  <= bin_count;
    end
  end

  assign res.valid          = out_valid;
  assign res.job_count      = out_stat.job_count;
  assign res.exec_total     = out_stat.exec_total;
  assign res.exec_min       = out_stat.exec_min;
  assign res.exec_max       = out_stat.exec_max;
  assign res.response_total = out_stat.response_total;
  assign res.response_min   = out_stat.response_min;
  assign res.response_max   = out_stat.response_max;
  assign res.miss_count     = out_stat.miss_count;
  assign res.worst_lateness = out_stat.worst_lateness;
  assign res.missed_now     = out_stat.missed_now;
  assign res.bin_count      = out_bin;

endmodule

### sv/jtsm_checker.sv
// ----------------------------------------------------------------------------
// Job timing statistics monitor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "job_timing_statistics_monitor_macros.svh"

module jtsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] job_count,
  input logic [47:0] exec_total,
  input logic [31:0] exec_min,
  input logic [31:0] exec_max,
  input logic [47:0] response_total,
  input logic [31:0] response_min,
  input logic [31:0] response_max,
  input logic [31:0] miss_count,
  input logic [31:0] worst_lateness,
  input logic        missed_now,
  input logic [31:0] bin_count
);

  logic [352:0] payload;
  logic         stalled;
  logic         zero_ok;
  logic         miss_ok;
  logic         order_ok;

  assign payload = {job_count, exec_total, exec_min, exec_max, response_total,
                    response_min, response_max, miss_count, worst_lateness,
                    missed_now, bin_count};

  assign stalled  = res_valid && !res_ready;
  assign zero_ok  = exec_total == 48'd0 && response_total == 48'd0 &&
                    miss_count == 32'd0 && worst_lateness == 32'd0 &&
                    !missed_now && bin_count == 32'd0;
  assign miss_ok  = miss_count != 32'd0 && worst_lateness != 32'd0 &&
                    response_max != 32'd0;
  assign order_ok = exec_min <= exec_max && response_min <= response_max;

  `JTSM_ASSERT_NEXT(a_stall_hold, clk, rst, stalled, res_valid && $stable(payload))
  `JTSM_ASSERT_NOW(a_empty_zero, clk, rst, res_valid && job_count == 32'd0, zero_ok)
  `JTSM_ASSERT_NOW(a_miss_seen, clk, rst, res_valid && missed_now, miss_ok)
  `JTSM_ASSERT_NOW(a_min_max, clk, rst, res_valid && job_count != 32'd0, order_ok)

endmodule

bind job_timing_statistics_monitor jtsm_checker u_jtsm_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .job_count(res.job_count),
  .exec_total(res.exec_total),
  .exec_min(res.exec_min),
  .exec_max(res.exec_max),
  .response_total(res.response_total),
  .response_min(res.response_min),
  .response_max(res.response_max),
  .miss_count(res.miss_count),
  .worst_lateness(res.worst_lateness),
  .missed_now(res.missed_now),
  .bin_count(res.bin_count)
);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Job timing statistics monitor testbench
// Drives job record and clear transactions with random idle bursts on both
// channels and checks every result against a cycle-free model of the
// statistics: totals with saturation, min/max, histogram and deadline misses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam int NUM_BINS = 10;

  typedef struct {
    jtsm_pkg::op_t op;
    logic [31:0]   exec_us;
    logic [31:0]   resp_us;
    logic [3:0]    sel;
  } job_txn_t;

  typedef struct {
    logic [31:0] job_count;
    logic [47:0] exec_total;
    logic [31:0] exec_min;
    logic [31:0] exec_max;
    logic [47:0] response_total;
    logic [31:0] response_min;
    logic [31:0] response_max;
    logic [31:0] miss_count;
    logic [31:0] worst_lateness;
    logic        missed_now;
    logic [31:0] bin_count;
  } stats_view_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;

  jtsm_in_if  job_ch ();
  jtsm_out_if stat_ch ();

  job_timing_statistics_monitor dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (job_ch),
    .res      (stat_ch)
  );

  logic [31:0] bin_edge_us [0:8] = '{32'd5000, 32'd10000, 32'd15000, 32'd20000,
                                     32'd25000, 32'd30000, 32'd32000, 32'd34000,
                                     32'd36000};

  logic [31:0] limit_us;
  logic [31:0] n_jobs;
  logic [47:0] exec_acc;
  logic [31:0] exec_lo;
  logic [31:0] exec_hi;
  logic [47:0] resp_acc;
  logic [31:0] resp_lo;
  logic [31:0] resp_hi;
  logic [31:0] n_misses;
  logic [31:0] late_peak;
  logic [31:0] hist_cnt [0:NUM_BINS-1];

  job_txn_t    job_backlog [$];
  stats_view_t stats_due [$];
  job_txn_t    next_job;
  job_txn_t    taken_job;
  stats_view_t seen;

  bit          in_taken;
  bit          send_idle;
  bit          recv_idle;
  int          send_gap;
  int          recv_gap;
  int          mismatches;
  int unsigned cycles;

  always #10 clk = ~clk;

  function automatic logic [31:0] bump_sat(input logic [31:0] v);
    return (v == MAX32) ? MAX32 : v + 32'd1;
  endfunction

  function automatic logic [47:0] add_sat(input logic [47:0] acc, input logic [31:0] v);
    logic [48:0] wide;
    wide = {1'b0, acc} + {17'd0, v};
    return wide[48] ? MAX48 : wide[47:0];
  endfunction

  function automatic int exec_bin(input logic [31:0] t);
    int idx;
    bit found;
    idx = NUM_BINS - 1;
    found = 0;
    for (int k = 0; k < NUM_BINS - 1; k++) begin
      if (!found && t < bin_edge_us[k]) begin
        idx = k;
        found = 1;
      end
    end
    return idx;
  endfunction

  function automatic void zero_stats();
    n_jobs = '0;
    exec_acc = '0;
    exec_lo = '0;
    exec_hi = '0;
    resp_acc = '0;
    resp_lo = '0;
    resp_hi = '0;
    n_misses = '0;
    late_peak = '0;
    for (int k = 0; k < NUM_BINS; k++) begin
      hist_cnt[k] = '0;
    end
  endfunction

  function automatic stats_view_t account_job(input job_txn_t j);
    stats_view_t r;
    bit first;
    int b;
    r.missed_now = 1'b0;
    if (j.op == jtsm_pkg::OP_CLEAR) begin
      zero_stats();
    end else begin
      first = (n_jobs == '0);
      n_jobs = bump_sat(n_jobs);
      exec_acc = add_sat(exec_acc, j.exec_us);
      resp_acc = add_sat(resp_acc, j.resp_us);
      if (first) begin
        exec_lo = j.exec_us;
        exec_hi = j.exec_us;
        resp_lo = j.resp_us;
        resp_hi = j.resp_us;
      end else begin
        if (j.exec_us < exec_lo) exec_lo = j.exec_us;
        if (j.exec_us > exec_hi) exec_hi = j.exec_us;
        if (j.resp_us < resp_lo) resp_lo = j.resp_us;
        if (j.resp_us > resp_hi) resp_hi = j.resp_us;
      end
      b = exec_bin(j.exec_us);
      hist_cnt[b] = bump_sat(hist_cnt[b]);
      if (j.resp_us > limit_us) begin
        r.missed_now = 1'b1;
        n_misses = bump_sat(n_misses);
        if (j.resp_us - limit_us > late_peak) late_peak = j.resp_us - limit_us;
      end
    end
    r.job_count = n_jobs;
    r.exec_total = exec_acc;
    r.exec_min = exec_lo;
    r.exec_max = exec_hi;
    r.response_total = resp_acc;
    r.response_min = resp_lo;
    r.response_max = resp_hi;
    r.miss_count = n_misses;
    r.worst_lateness = late_peak;
    r.bin_count = (j.sel < NUM_BINS) ? hist_cnt[j.sel] : 32'd0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  task automatic check_stats(input stats_view_t want, input stats_view_t got);
    check_field("job_count", want.job_count, got.job_count);
    check_field("exec_total", want.exec_total, got.exec_total);
    check_field("exec_min", want.exec_min, got.exec_min);
    check_field("exec_max", want.exec_max, got.exec_max);
    check_field("response_total", want.response_total, got.response_total);
    check_field("response_min", want.response_min, got.response_min);
    check_field("response_max", want.response_max, got.response_max);
    check_field("miss_count", want.miss_count, got.miss_count);
    check_field("worst_lateness", want.worst_lateness, got.worst_lateness);
    check_field("missed_now", want.missed_now, got.missed_now);
    check_field("bin_count", want.bin_count, got.bin_count);
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sample accepted transactions, predict, and check results
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 0;
      limit_us = '0;
      zero_stats();
      stats_due.delete();
    end else begin
      if (cfg_we) begin
        limit_us = cfg_data;
      end
      in_taken = job_ch.valid && job_ch.ready;
      if (in_taken) begin
        taken_job.op = jtsm_pkg::op_t'(job_ch.opcode);
        taken_job.exec_us = job_ch.exec_time;
        taken_job.resp_us = job_ch.response_time;
        taken_job.sel = job_ch.bin_select;
        stats_due.push_back(account_job(taken_job));
      end
      if (stat_ch.valid && stat_ch.ready) begin
        seen.job_count = stat_ch.job_count;
        seen.exec_total = stat_ch.exec_total;
        seen.exec_min = stat_ch.exec_min;
        seen.exec_max = stat_ch.exec_max;
        seen.response_total = stat_ch.response_total;
        seen.response_min = stat_ch.response_min;
        seen.response_max = stat_ch.response_max;
        seen.miss_count = stat_ch.miss_count;
        seen.worst_lateness = stat_ch.worst_lateness;
        seen.missed_now = stat_ch.missed_now;
        seen.bin_count = stat_ch.bin_count;
        if (stats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: job_count %0h", seen.job_count);
          end
        end else begin
          check_stats(stats_due.pop_front(), seen);
        end
      end
    end
  end

  // Job channel driver: hold valid until accepted, idle in bursts
  always @(negedge clk) begin
    if (!rst && (!job_ch.valid || in_taken)) begin
      if (send_gap > 0) begin
        job_ch.valid <= 1'b0;
        send_gap--;
      end else if (send_idle && $urandom_range(0, 7) == 0) begin
        job_ch.valid <= 1'b0;
        send_gap = $urandom_range(0, 17);
      end else if (job_backlog.size() > 0) begin
        next_job = job_backlog.pop_front();
        job_ch.opcode <= next_job.op;
        job_ch.exec_time <= next_job.exec_us;
        job_ch.response_time <= next_job.resp_us;
        job_ch.bin_select <= next_job.sel;
        job_ch.valid <= 1'b1;
      end else begin
        job_ch.valid <= 1'b0;
      end
    end
  end

  // Result channel ready with stall bursts
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      stat_ch.ready <= 1'b0;
      recv_gap--;
    end else if (!rst && recv_idle && $urandom_range(0, 7) == 0) begin
      stat_ch.ready <= 1'b0;
      recv_gap = $urandom_range(0, 17);
    end else begin
      stat_ch.ready <= 1'b1;
    end
  end

  task automatic queue_job(input jtsm_pkg::op_t op, input logic [31:0] e,
                           input logic [31:0] r, input logic [3:0] s);
    job_txn_t j;
    j.op = op;
    j.exec_us = e;
    j.resp_us = r;
    j.sel = s;
    job_backlog.push_back(j);
  endtask

  task automatic queue_random_jobs(input int count);
    logic [31:0] e;
    logic [31:0] r;
    logic [3:0] s;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 7))
        0, 1: e = bin_edge_us[$urandom_range(0, 8)] + $urandom_range(0, 2) - 1;
        2, 3, 4: e = $urandom_range(0, 40000);
        5: e = $urandom;
        6: e = ($urandom_range(0, 1) == 0) ? 32'd0 : MAX32;
        default: e = $urandom_range(0, 4999);
      endcase
      case ($urandom_range(0, 5))
        0: r = limit_us + $urandom_range(0, 2) - 1;
        1, 2: r = $urandom_range(0, 60000);
        3: r = $urandom;
        4: r = ($urandom_range(0, 1) == 0) ? 32'd0 : MAX32;
        default: r = limit_us + $urandom_range(0, 5000);
      endcase
      s = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      queue_job(($urandom_range(0, 39) == 0) ? jtsm_pkg::OP_CLEAR : jtsm_pkg::OP_RECORD,
                e, r, s);
    end
  endtask

  task automatic wait_quiet();
    do begin
      @(posedge clk);
    end while (job_backlog.size() != 0 || job_ch.valid || stats_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_deadline(input logic [31:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    job_ch.valid = 1'b0;
    job_ch.opcode = 1'b0;
    job_ch.exec_time = '0;
    job_ch.response_time = '0;
    job_ch.bin_select = '0;
    stat_ch.ready = 1'b0;
    send_idle = 1;
    recv_idle = 1;
    send_gap = 0;
    recv_gap = 0;
    mismatches = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_job(jtsm_pkg::OP_RECORD, 32'd0, 32'd0, 4'd0);
    queue_job(jtsm_pkg::OP_RECORD, MAX32, MAX32, 4'd9);
    queue_job(jtsm_pkg::OP_RECORD, 32'd4999, 32'd1, 4'd0);
    queue_job(jtsm_pkg::OP_RECORD, 32'd5000, 32'd2, 4'd1);
    queue_job(jtsm_pkg::OP_RECORD, 32'd35999, 32'd3, 4'd8);
    queue_job(jtsm_pkg::OP_RECORD, 32'd36000, 32'd4, 4'd9);
    queue_job(jtsm_pkg::OP_RECORD, 32'd12345, 32'd0, 4'd10);
    queue_job(jtsm_pkg::OP_RECORD, 32'd1, 32'd5, 4'd15);
    queue_job(jtsm_pkg::OP_CLEAR, 32'd777, 32'd888, 4'd9);
    queue_job(jtsm_pkg::OP_RECORD, 32'd20000, 32'd7, 4'd4);
    queue_job(jtsm_pkg::OP_RECORD, 32'd19999, 32'd8, 4'd3);

    set_deadline(32'd1000);
    queue_job(jtsm_pkg::OP_RECORD, 32'd30000, 32'd999, 4'd6);
    queue_job(jtsm_pkg::OP_RECORD, 32'd31999, 32'd1000, 4'd5);
    queue_job(jtsm_pkg::OP_RECORD, 32'd32000, 32'd1001, 4'd6);
    queue_job(jtsm_pkg::OP_RECORD, 32'd33999, 32'd500, 4'd6);
    queue_job(jtsm_pkg::OP_RECORD, 32'd34000, 32'd2000, 4'd7);
    queue_job(jtsm_pkg::OP_CLEAR, 32'd0, 32'd0, 4'd0);
    queue_job(jtsm_pkg::OP_CLEAR, MAX32, MAX32, 4'd12);
    queue_job(jtsm_pkg::OP_RECORD, 32'd0, MAX32, 4'd0);

    set_deadline(MAX32);
    queue_random_jobs(200);

    set_deadline(32'd0);
    queue_random_jobs(200);

    set_deadline($urandom_range(5000, 40000));
    recv_idle = 0;
    queue_random_jobs(250);

    // Run of near-maximum times
    set_deadline($urandom);
    recv_idle = 1;
    queue_job(jtsm_pkg::OP_CLEAR, 32'd0, 32'd0, 4'd9);
    for (int n = 0; n < 30; n++) begin
      queue_job(jtsm_pkg::OP_RECORD, MAX32 - $urandom_range(0, 255),
                MAX32 - $urandom_range(0, 255), 4'($urandom_range(0, 15)));
    end

    set_deadline($urandom_range(20000, 36000));
    queue_job(jtsm_pkg::OP_CLEAR, 32'd0, 32'd0, 4'd0);
    queue_random_jobs(300);

    set_deadline($urandom);
    wait_quiet();
    send_idle = 0;
    recv_idle = 0;
    queue_random_jobs(250);

    wait_quiet();
    repeat (8) @(posedge clk);
    if (stats_due.size() != 0) begin
      mismatches += stats_due.size();
      $display("%0d expected results never arrived", stats_due.size());
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
